>>> rtl/lspg_pkg.sv
// ----------------------------------------------------------------------------
// lspg_pkg
// Shared types, constants and the color wheel function of the led strip
// pattern generator.
// ----------------------------------------------------------------------------
package lspg_pkg;

  // field widths
  localparam int COUNT_W = 7;
  localparam int MODE_W  = 2;
  localparam int COLOR_W = 24;
  localparam int HUE_W   = 8;
  localparam int PHASE_W = 2;
  localparam int INDEX_W = 6;
  localparam int CHAN_W  = 8;
  localparam int STEP_W  = 9;
  localparam int CFG_IDX_W = 2;

  // default strip size
  localparam int MAX_PIXELS_DEF = 64;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHASE_COLOR  = 2'd2;

  // reset values of the configuration registers
  localparam logic [COUNT_W-1:0] PIXEL_COUNT_RST  = 7'd20;
  localparam logic [MODE_W-1:0]  PATTERN_MODE_RST = 2'd1;
  localparam logic [COLOR_W-1:0] CHASE_COLOR_RST  = 24'd0;

  // pattern modes
  localparam logic [MODE_W-1:0] MODE_RAINBOW       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CYCLE         = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHASE         = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CHASE_RAINBOW = 2'd3;

  // last chase phase before wrapping
  localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd2;

  // descriptor queue depth
  localparam int QUEUE_DEPTH = 2;

  // one frame as handed from front to back
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MODE_W-1:0]  mode;
    logic [COLOR_W-1:0] color;
    logic [HUE_W-1:0]   hue;
    logic [PHASE_W-1:0] phase;
    logic [STEP_W-1:0]  step;
    logic [COUNT_W-1:0] rem;
  } frame_desc_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // color wheel: three segments split at 85 and 170 on the inverted position
  function automatic rgb_t wheel(input logic [HUE_W-1:0] pos);
    logic [HUE_W-1:0] q;
    logic [HUE_W-1:0] t;
    rgb_t             c;
    q = 8'd255 - pos;
    c = '0;
    if (q < 8'd85) begin
      t   = 8'(q * 2'd3);
      c.r = 8'd255 - t;
      c.b = t;
    end else if (q < 8'd170) begin
      t   = 8'((q - 8'd85) * 2'd3);
      c.g = t;
      c.b = 8'd255 - t;
    end else begin
      t   = 8'((q - 8'd170) * 2'd3);
      c.r = t;
      c.g = 8'd255 - t;
    end
    return c;
  endfunction

endpackage

>>> rtl/lspg_front.sv
// ----------------------------------------------------------------------------
// lspg_front
// Takes frame ticks, holds the configuration and the hue and chase counters,
// works out the per-pixel cycle step by a bit-serial divider and queues a
// frame descriptor.
// ----------------------------------------------------------------------------
module lspg_front #(
  parameter int MAX_PIXELS = lspg_pkg::MAX_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_restart,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lspg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lspg_pkg::COLOR_W-1:0]    cfg_data,
  output logic                            push_valid,
  input  logic                            push_ready,
  output lspg_pkg::frame_desc_t           push_desc
);
  import lspg_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  localparam logic [STEP_W-1:0]  DIVIDEND = 9'd256;
  localparam logic [COUNT_W-1:0] MAX_CNT  = COUNT_W'(MAX_PIXELS);

  fstate_t              state_r, state_nxt;
  logic [COUNT_W-1:0]   pixel_count_r;
  logic [MODE_W-1:0]    pattern_mode_r;
  logic [COLOR_W-1:0]   chase_color_r;
  logic [HUE_W-1:0]     hue_r, hue_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  frame_desc_t          desc_r, desc_nxt;
  logic [COUNT_W:0]     div_rem_r, div_rem_nxt;
  logic [STEP_W-1:0]    div_quo_r, div_quo_nxt;
  logic [3:0]           div_cnt_r, div_cnt_nxt;

  logic                 accept;
  logic [COUNT_W-1:0]   count_sat;
  logic [HUE_W-1:0]     hue_eff;
  logic [PHASE_W-1:0]   phase_eff;
  logic [COUNT_W:0]     trial;

  assign in_ready   = (state_r == F_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && in_ready;
  assign push_valid = (state_r == F_PUSH);
  assign push_desc  = desc_r;

  // frame size clamped to the strip length
  assign count_sat = (pixel_count_r > MAX_CNT) ? MAX_CNT : pixel_count_r;

  // restart clears counters ahead of this frame
  assign hue_eff   = in_restart ? '0 : hue_r;
  assign phase_eff = in_restart ? '0 : phase_r;

  // counter advance after the frame
  always_comb begin
    hue_nxt   = hue_eff;
    phase_nxt = phase_eff;
    if (pattern_mode_r == MODE_CHASE_RAINBOW) begin
      if (phase_eff >= PHASE_LAST) begin
        phase_nxt = '0;
        hue_nxt   = hue_eff + 1'b1;
      end else begin
        phase_nxt = phase_eff + 1'b1;
      end
    end else begin
      hue_nxt = hue_eff + 1'b1;
      if (pattern_mode_r == MODE_CHASE) begin
        phase_nxt = (phase_eff >= PHASE_LAST) ? '0 : phase_eff + 1'b1;
      end
    end
  end

  // one restoring divide step per cycle: 256 / count
  assign trial = {div_rem_r[COUNT_W-1:0], DIVIDEND[div_cnt_r]};

  always_comb begin
    state_nxt   = state_r;
    desc_nxt    = desc_r;
    div_rem_nxt = div_rem_r;
    div_quo_nxt = div_quo_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          desc_nxt.count = count_sat;
          desc_nxt.mode  = pattern_mode_r;
          desc_nxt.color = chase_color_r;
          desc_nxt.hue   = hue_eff;
          desc_nxt.phase = phase_eff;
          div_rem_nxt    = '0;
          div_quo_nxt    = '0;
          div_cnt_nxt    = 4'(STEP_W - 1);
          state_nxt      = F_DIV;
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, desc_r.count}) begin
          div_rem_nxt = trial - {1'b0, desc_r.count};
          div_quo_nxt = {div_quo_r[STEP_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = trial;
          div_quo_nxt = {div_quo_r[STEP_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          desc_nxt.step = div_quo_nxt;
          desc_nxt.rem  = div_rem_nxt[COUNT_W-1:0];
          state_nxt     = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // state, configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= F_IDLE;
      pixel_count_r  <= PIXEL_COUNT_RST;
      pattern_mode_r <= PATTERN_MODE_RST;
      chase_color_r  <= CHASE_COLOR_RST;
      hue_r          <= '0;
      phase_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PIXEL_COUNT:  pixel_count_r  <= cfg_data[COUNT_W-1:0];
          CFG_PATTERN_MODE: pattern_mode_r <= cfg_data[MODE_W-1:0];
          CFG_CHASE_COLOR:  chase_color_r  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        hue_r   <= hue_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    desc_r    <= desc_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_cnt_r <= div_cnt_nxt;
  end

endmodule

>>> rtl/lspg_queue.sv
// ----------------------------------------------------------------------------
// lspg_queue
// Small descriptor queue between the front and back sections.
// ----------------------------------------------------------------------------
module lspg_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  lspg_pkg::frame_desc_t push_desc,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output lspg_pkg::frame_desc_t pop_desc
);
  import lspg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  frame_desc_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     fill_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_desc   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_desc;
  end

endmodule

>>> rtl/lspg_back.sv
// ----------------------------------------------------------------------------
// lspg_back
// Walks the pixels of a queued frame, one per cycle unless the result channel
// stalls, and drives the result channel through an output register.
// ----------------------------------------------------------------------------
module lspg_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  lspg_pkg::frame_desc_t           pop_desc,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lspg_pkg::INDEX_W-1:0]    out_pixel_index,
  output logic [lspg_pkg::CHAN_W-1:0]     out_red,
  output logic [lspg_pkg::CHAN_W-1:0]     out_green,
  output logic [lspg_pkg::CHAN_W-1:0]     out_blue,
  output logic                            out_last_pixel
);
  import lspg_pkg::*;

  logic                busy_r;
  frame_desc_t         d_r;
  logic [COUNT_W-1:0]  idx_r;
  logic [1:0]          mod3_r;
  logic [STEP_W-1:0]   q_r;
  logic [COUNT_W-1:0]  r_r;
  logic                out_valid_r;
  logic [INDEX_W-1:0]  pix_r;
  rgb_t                rgb_r;
  logic                last_r;

  logic                load;
  logic                take;
  logic                last;
  logic                lit;
  logic [COUNT_W:0]    r_sum;
  logic [HUE_W:0]      cr_sum;
  logic [HUE_W-1:0]    cr_pos;
  rgb_t                color;

  assign pop_ready = !busy_r;
  assign take      = pop_valid && pop_ready;
  assign load      = busy_r && (!out_valid_r || out_ready);
  assign last      = ((idx_r + 1'b1) == d_r.count);
  assign lit       = (mod3_r == d_r.phase);

  // chase rainbow position, taken mod 255
  assign cr_sum = (HUE_W+1)'(idx_r - COUNT_W'(d_r.phase)) + (HUE_W+1)'(d_r.hue);
  assign cr_pos = (cr_sum >= 9'd255) ? HUE_W'(cr_sum - 9'd255) : cr_sum[HUE_W-1:0];

  // remainder accumulation for the cycle mode
  assign r_sum = {1'b0, r_r} + {1'b0, d_r.rem};

  // pixel color
  always_comb begin
    color = '0;
    unique case (d_r.mode)
      MODE_RAINBOW:  color = wheel(HUE_W'(idx_r) + d_r.hue);
      MODE_CYCLE:    color = wheel(q_r[HUE_W-1:0] + d_r.hue);
      MODE_CHASE: begin
        if (lit) color = d_r.color;
      end
      MODE_CHASE_RAINBOW: begin
        if (lit) color = wheel(cr_pos);
      end
      default: color = '0;
    endcase
  end

  // frame walk and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (take) begin
        busy_r <= (pop_desc.count != '0);
      end else if (load) begin
        out_valid_r <= 1'b1;
        if (last) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      d_r    <= pop_desc;
      idx_r  <= '0;
      mod3_r <= '0;
      q_r    <= '0;
      r_r    <= '0;
    end else if (load) begin
      idx_r  <= idx_r + 1'b1;
      mod3_r <= (mod3_r == 2'd2) ? 2'd0 : mod3_r + 1'b1;
      if (r_sum >= {1'b0, d_r.count}) begin
        r_r <= COUNT_W'(r_sum - {1'b0, d_r.count});
        q_r <= q_r + d_r.step + 1'b1;
      end else begin
        r_r <= r_sum[COUNT_W-1:0];
        q_r <= q_r + d_r.step;
      end
    end
    if (load) begin
      pix_r  <= idx_r[INDEX_W-1:0];
      rgb_r  <= color;
      last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = pix_r;
  assign out_red         = rgb_r.r;
  assign out_green       = rgb_r.g;
  assign out_blue        = rgb_r.b;
  assign out_last_pixel  = last_r;

endmodule

>>> rtl/led_strip_pattern_generator_top.sv
// Path: after acceptance, a tick's first pixel passes the bit-serial divide of 256 by the
// pixel count, the push, the queue pop and the output register.
// Throughput: one pixel result per cycle while out_ready holds; the front takes no new tick
// until its descriptor is pushed, and the back pops the next frame after its last pixel.
// Reset: synchronous active-low rst_n clears hue, chase phase, queue and
// handshakes and loads the configuration defaults (20 pixels, cycle mode).
// ----------------------------------------------------------------------------
// led_strip_pattern_generator_top
// Color wheel rainbow and theater chase pattern generator for an RGB strip.
// ----------------------------------------------------------------------------
module led_strip_pattern_generator_top #(
  parameter int MAX_PIXELS = lspg_pkg::MAX_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_restart,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lspg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lspg_pkg::COLOR_W-1:0]    cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lspg_pkg::INDEX_W-1:0]    out_pixel_index,
  output logic [lspg_pkg::CHAN_W-1:0]     out_red,
  output logic [lspg_pkg::CHAN_W-1:0]     out_green,
  output logic [lspg_pkg::CHAN_W-1:0]     out_blue,
  output logic                            out_last_pixel
);
  import lspg_pkg::*;

  logic        push_valid;
  logic        push_ready;
  frame_desc_t push_desc;
  logic        pop_valid;
  logic        pop_ready;
  frame_desc_t pop_desc;

  // tick intake and frame setup
  lspg_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  // frame descriptor queue
  lspg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  // pixel walk and result channel
  lspg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_desc        (pop_desc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel)
  );

endmodule
